### src/mpsw_pkg.sv
// shared constants and helper functions for the wrapped-grid max path sum block
`timescale 1ns / 1ps
package mpsw_pkg;

	localparam int MAX_COLUMNS_DEF = 64;

	localparam int ELEM_W    = 16;
	localparam int SUM_W     = 32;
	localparam int MAX_SUM_W = 31;
	localparam int CC_W      = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [CC_W-1:0] CC_RESET = 7'd64;

	// register index, taken from paddr bit 2
	localparam logic REG_COLUMN_COUNT = 1'b0;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > (SUM_W+1)'(SUM_MAX)) begin
			r = SUM_MAX;
		end else if (v < (SUM_W+1)'(SUM_MIN)) begin
			r = SUM_MIN;
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] max3(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b,
		input logic signed [SUM_W-1:0] c
	);
		logic signed [SUM_W-1:0] r;
		r = a;
		if (b > r) begin
			r = b;
		end
		if (c > r) begin
			r = c;
		end
		return r;
	endfunction

endpackage

### src/mpsw_row_store.sv
// row store of best path sums: one write port, one read port with registered data
`timescale 1ns / 1ps
module mpsw_row_store import mpsw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	localparam int AW = $clog2(MAX_COLUMNS)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [SUM_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [SUM_W-1:0] rdata
);

	logic signed [SUM_W-1:0] mem [MAX_COLUMNS];
	logic signed [SUM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a read of the entry being written returns the new sum
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### src/mpsw_cfg.sv
// apb configuration register for the column count
`timescale 1ns / 1ps
module mpsw_cfg import mpsw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	localparam int AW = $clog2(MAX_COLUMNS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [AW-1:0]     last_col,
	output logic              restart
);

	localparam int CNT_W = (AW + 1 > CC_W) ? AW + 1 : CC_W;

	// last column index of the clamped count
	function automatic logic [AW-1:0] clamp_last(input logic [CC_W-1:0] cc);
		logic [CNT_W-1:0] ext;
		logic [CNT_W-1:0] r;
		ext = CNT_W'(cc);
		if (ext < CNT_W'(2)) begin
			r = CNT_W'(1);
		end else if (ext > CNT_W'(MAX_COLUMNS)) begin
			r = CNT_W'(MAX_COLUMNS - 1);
		end else begin
			r = ext - CNT_W'(1);
		end
		return r[AW-1:0];
	endfunction

	logic [CC_W-1:0] column_count_q;
	logic [AW-1:0]   last_col_q;
	logic            wr_cc;

	assign pready = 1'b1;
	assign wr_cc  = psel && penable && pwrite && pready && (paddr[2] == REG_COLUMN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= CC_RESET;
			last_col_q     <= clamp_last(CC_RESET);
		end else if (wr_cc) begin
			column_count_q <= pwdata[CC_W-1:0];
			last_col_q     <= clamp_last(pwdata[CC_W-1:0]);
		end
	end

	always_comb begin
		if (paddr[2] == REG_COLUMN_COUNT) begin
			prdata = APB_DW'(column_count_q);
		end else begin
			prdata = '0;
		end
	end

	assign last_col = last_col_q;
	assign restart  = wr_cc;

endmodule

### src/mpsw_core.sv
// input register, row recurrence and result register
`timescale 1ns / 1ps
module mpsw_core import mpsw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	localparam int AW = $clog2(MAX_COLUMNS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     final_element,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [MAX_SUM_W-1:0]     max_sum,
	output logic                     incomplete_row,
	input  logic [AW-1:0]            last_col,
	input  logic                     restart,
	output logic                     st_we,
	output logic [AW-1:0]            st_waddr,
	output logic signed [SUM_W-1:0]  st_wdata,
	output logic                     st_re,
	output logic [AW-1:0]            st_raddr,
	input  logic signed [SUM_W-1:0]  st_rdata
);

	logic                     valid_s1;
	logic signed [ELEM_W-1:0] elem_s1;
	logic                     final_s1;

	logic [AW-1:0]           col_q;
	logic                    first_row_q;
	logic signed [SUM_W-1:0] here_q;
	logic signed [SUM_W-1:0] left_q;
	logic signed [SUM_W-1:0] col0_prev_q;
	logic signed [SUM_W-1:0] cur_col0_q;
	logic signed [SUM_W-1:0] prev_sum_q;
	logic signed [SUM_W-1:0] row_best_q;

	logic                 out_valid_q;
	logic [MAX_SUM_W-1:0] max_sum_q;
	logic                 incomplete_q;

	logic                    proc;
	logic                    at_zero;
	logic                    at_end;
	logic [AW-1:0]           col_n;
	logic signed [SUM_W-1:0] left_v;
	logic signed [SUM_W-1:0] right_v;
	logic signed [SUM_W-1:0] best_above;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] row_best_n;

	// an item leaves the input register unless it is final and a held result is not taken
	assign proc     = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			elem_s1  <= element_value;
			final_s1 <= final_element;
		end
	end

	assign at_zero = (col_q == '0);
	assign at_end  = (col_q == last_col);
	assign col_n   = at_end ? '0 : col_q + AW'(1);

	// column zero's left neighbor is the last column, computed one item ago
	assign left_v     = at_zero ? prev_sum_q : left_q;
	assign right_v    = at_end ? col0_prev_q : st_rdata;
	assign best_above = max3(left_v, here_q, right_v);

	always_comb begin
		if (first_row_q) begin
			sum = SUM_W'(elem_s1);
		end else begin
			sum = sat_sum((SUM_W+1)'(elem_s1) + (SUM_W+1)'(best_above));
		end
	end

	always_comb begin
		if (at_zero || (sum > row_best_q)) begin
			row_best_n = sum;
		end else begin
			row_best_n = row_best_q;
		end
	end

	// store: write this column, prefetch the right neighbor of the next column
	assign st_we    = proc;
	assign st_waddr = col_q;
	assign st_wdata = sum;
	assign st_re    = proc;
	assign st_raddr = col_n + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (restart || (proc && final_s1)) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (proc) begin
			col_q <= col_n;
			if (at_end) begin
				first_row_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			row_best_q <= '0;
		end else if (proc) begin
			row_best_q <= final_s1 ? '0 : row_best_n;
			prev_sum_q <= sum;
			left_q     <= here_q;
			here_q     <= at_end ? cur_col0_q : st_rdata;
			if (at_zero) begin
				col0_prev_q <= here_q;
				cur_col0_q  <= sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && final_s1) begin
			max_sum_q    <= (row_best_n > 0) ? row_best_n[MAX_SUM_W-1:0] : '0;
			incomplete_q <= !at_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign max_sum        = max_sum_q;
	assign incomplete_row = incomplete_q;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col)
		else $error("column index beyond last column");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc && final_s1 |=> out_valid_q)
		else $error("final transaction produced no result");

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		proc && final_s1 |=> (col_q == '0) && first_row_q)
		else $error("matrix not restarted after final transaction");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && final_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a pending result");

endmodule

### src/max_path_sum_wrapped_grid_top.sv
// Maximum path sum down a matrix whose columns wrap around the sides. Elements
// arrive in row-major order and one transaction is accepted every clock cycle; the
// final element passes through the input register, then the result register, which
// raises out_valid. The rate is set by the row store, which takes one write and one
// prefetching read per element; the two other neighbor sums come from registers. A
// result waiting in the output register only holds off a further final element.
// Writing column_count restarts the current matrix.
`timescale 1ns / 1ps
module max_path_sum_wrapped_grid_top import mpsw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     final_element,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [MAX_SUM_W-1:0]     max_sum,
	output logic                     incomplete_row
);

	localparam int AW = $clog2(MAX_COLUMNS);

	logic [AW-1:0]           last_col;
	logic                    restart;
	logic                    st_we;
	logic [AW-1:0]           st_waddr;
	logic signed [SUM_W-1:0] st_wdata;
	logic                    st_re;
	logic [AW-1:0]           st_raddr;
	logic signed [SUM_W-1:0] st_rdata;

	mpsw_cfg #(.MAX_COLUMNS(MAX_COLUMNS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.last_col (last_col),
		.restart  (restart)
	);

	mpsw_row_store #(.MAX_COLUMNS(MAX_COLUMNS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mpsw_core #(.MAX_COLUMNS(MAX_COLUMNS)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.element_value  (element_value),
		.final_element  (final_element),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.max_sum        (max_sum),
		.incomplete_row (incomplete_row),
		.last_col       (last_col),
		.restart        (restart),
		.st_we          (st_we),
		.st_waddr       (st_waddr),
		.st_wdata       (st_wdata),
		.st_re          (st_re),
		.st_raddr       (st_raddr),
		.st_rdata       (st_rdata)
	);

endmodule

### test/tb_max_path_sum_wrapped_grid_top.sv
// testbench for the wrapped-grid max path sum block: directed table, extreme-value floods, random matrices
`timescale 1ns / 1ps
module tb_max_path_sum_wrapped_grid_top;
	import mpsw_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int FLOOD_ROWS   = 16;

	typedef struct packed {
		logic [MAX_SUM_W-1:0] sum;
		logic                 inc;
	} path_result_t;

	typedef enum bit {ROW_ELEMENT, ROW_COLUMN_WRITE} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CC_W-1:0]         cols;
		logic signed [ELEM_W-1:0] elem;
		logic                    fin;
		bit                      typed;
		path_result_t            res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [ELEM_W-1:0] element_value;
	logic final_element;
	logic [MAX_SUM_W-1:0] max_sum;
	logic incomplete_row;

	// predictor state
	logic signed [SUM_W-1:0] path_sums [MAX_COLUMNS_DEF];
	int unsigned col_idx;
	bit          first_row;
	logic signed [SUM_W-1:0] left_prev, col0_prev, row_best;
	logic [CC_W-1:0] cols_reg;

	path_result_t expected_peaks[$];
	table_row_t   stim_table[$];
	int  errors = 0;
	int  cycle_count = 0;
	bit  gaps_on = 1'b1;
	bit  long_hold_req = 1'b0;
	bit  long_hold_done = 1'b0;

	max_path_sum_wrapped_grid_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.element_value(element_value), .final_element(final_element),
		.out_valid(out_valid), .out_ready(out_ready),
		.max_sum(max_sum), .incomplete_row(incomplete_row)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned cols_in_use();
		int unsigned m;
		m = 32'(cols_reg);
		if (m < 2) m = 2;
		if (m > MAX_COLUMNS_DEF) m = MAX_COLUMNS_DEF;
		return m;
	endfunction

	function automatic int unsigned draw_gap();
		if (!gaps_on || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic signed [ELEM_W-1:0] rand_element();
		case ($urandom_range(0, 5))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return ELEM_W'($signed($urandom_range(0, 200)) - 100);
			end
			default: begin
				return ELEM_W'($urandom);
			end
		endcase
	endfunction

	function automatic void restart_matrix();
		col_idx   = 0;
		first_row = 1'b1;
		row_best  = '0;
	endfunction

	// one element through the row recurrence; a result only on a final element
	task automatic step_path_sums(input logic signed [ELEM_W-1:0] e, input logic fin,
		output bit produced, output path_result_t res);
		int unsigned m, j;
		logic signed [SUM_W-1:0] here_old, lft, rgt, best_above, s;
		logic signed [SUM_W+1:0] wide;
		bit row_end;
		m = cols_in_use();
		j = col_idx;
		if (j >= m) j = m - 1;
		here_old = path_sums[j];
		if (first_row) begin
			s = SUM_W'(e);
		end else begin
			lft = (j == 0) ? path_sums[m-1] : left_prev;
			rgt = (j == m - 1) ? col0_prev : path_sums[j+1];
			best_above = lft;
			if (here_old > best_above) best_above = here_old;
			if (rgt > best_above) best_above = rgt;
			wide = (SUM_W+2)'(best_above) + (SUM_W+2)'(e);
			if (wide > SUM_MAX) s = SUM_MAX;
			else if (wide < SUM_MIN) s = SUM_MIN;
			else s = wide[SUM_W-1:0];
		end
		left_prev = here_old;
		if (j == 0) begin
			col0_prev = here_old;
			row_best  = s;
		end else if (s > row_best) begin
			row_best = s;
		end
		path_sums[j] = s;
		row_end = (j == m - 1);
		if (row_end) begin
			col_idx   = 0;
			first_row = 1'b0;
		end else begin
			col_idx = j + 1;
		end
		produced = fin;
		res = '0;
		if (fin) begin
			res.sum = (row_best > 0) ? row_best[MAX_SUM_W-1:0] : '0;
			res.inc = !row_end;
			restart_matrix();
		end
	endtask

	// offer one element, hold it until accepted, then predict
	task automatic push_element(input logic signed [ELEM_W-1:0] e, input logic fin,
		input bit typed, input path_result_t typed_res);
		int unsigned gap;
		bit produced;
		path_result_t res;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		element_value <= e;
		final_element <= fin;
		do @(posedge clk); while (!in_ready);
		step_path_sums(e, fin, produced, res);
		if (produced) expected_peaks.push_back(typed ? typed_res : res);
	endtask

	// wait for every result plus the pipeline latency
	task automatic drain_block();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (expected_peaks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_column_count(input logic [CC_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * REG_COLUMN_COUNT);
		pwdata  <= APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cols_reg = v;
		restart_matrix();
	endtask

	// m=2 matrix rows of one value, sent back to back
	task automatic flood_rows(input logic signed [ELEM_W-1:0] e, input int rows,
		input bit end_final);
		for (int i = 0; i < 2 * rows; i++) begin
			push_element(e, end_final && (i == 2 * rows - 1), 1'b0, '0);
		end
	endtask

	task automatic add_elem(input logic signed [ELEM_W-1:0] e, input logic fin);
		table_row_t r;
		r = '{ROW_ELEMENT, '0, e, fin, 1'b0, '0};
		stim_table.push_back(r);
	endtask

	task automatic add_elem_typed(input logic signed [ELEM_W-1:0] e, input logic fin,
		input logic [MAX_SUM_W-1:0] s, input logic inc);
		table_row_t r;
		r = '{ROW_ELEMENT, '0, e, fin, 1'b1, '{s, inc}};
		stim_table.push_back(r);
	endtask

	task automatic add_cols(input logic [CC_W-1:0] v);
		table_row_t r;
		r = '{ROW_COLUMN_WRITE, v, '0, 1'b0, 1'b0, '0};
		stim_table.push_back(r);
	endtask

	// result side
	initial begin : result_side
		int unsigned gap;
		path_result_t exp_res;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req && !long_hold_done) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			gap = draw_gap();
			if (gap > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_peaks.size() == 0) begin
				$display("%0t: unexpected transaction max_sum %0d incomplete_row %0b",
					$time, max_sum, incomplete_row);
				errors++;
			end else begin
				exp_res = expected_peaks.pop_front();
				if (max_sum !== exp_res.sum) begin
					$display("%0t: max_sum expected %0d actual %0d",
						$time, exp_res.sum, max_sum);
					errors++;
				end
				if (incomplete_row !== exp_res.inc) begin
					$display("%0t: incomplete_row expected %0b actual %0b",
						$time, exp_res.inc, incomplete_row);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int random_items;
		int phase;
		int n_mats, rows, len, style;
		int unsigned m;
		logic [CC_W-1:0] cc;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		element_value = '0;
		final_element = 1'b0;
		for (int i = 0; i < MAX_COLUMNS_DEF; i++) path_sums[i] = '0;
		left_prev = '0;
		col0_prev = '0;
		cols_reg  = CC_RESET;
		restart_matrix();

		// directed table
		add_elem_typed(16'sh7FFF, 1'b1, 31'd32767, 1'b1);
		add_elem_typed(16'sh8000, 1'b1, 31'd0, 1'b1);
		add_cols(7'd2);
		add_elem(16'sd5, 1'b0);
		add_elem(16'sd7, 1'b0);
		add_elem(16'sd3, 1'b0);
		add_elem(16'sd1, 1'b1);
		add_cols(7'd0);   // clamps to two columns
		add_elem_typed(-16'sd1, 1'b0, '0, 1'b0);
		add_elem_typed(-16'sd2, 1'b1, 31'd0, 1'b0);
		add_elem(16'sh7FFF, 1'b0);
		add_elem(16'sh7FFF, 1'b0);
		add_elem(16'sh7FFF, 1'b0);
		add_elem(16'sh8000, 1'b1);
		add_cols(7'd127); // clamps to the maximum
		add_elem_typed(16'sd100, 1'b0, '0, 1'b0);
		add_elem_typed(-16'sd5, 1'b1, 31'd100, 1'b1);
		add_cols(7'd3);
		add_elem(-16'sd3, 1'b0);
		add_elem(16'sd8, 1'b0);
		add_elem(-16'sd1, 1'b0);
		add_elem(16'sd4, 1'b0);
		add_elem(-16'sd6, 1'b0);
		add_elem(16'sd2, 1'b1);
		add_elem(16'sd1, 1'b0);
		add_elem(16'sd2, 1'b0);
		add_cols(7'd3);   // write mid-matrix restarts it
		add_elem_typed(16'sd4, 1'b0, '0, 1'b0);
		add_elem_typed(16'sd4, 1'b0, '0, 1'b0);
		add_elem_typed(16'sd4, 1'b1, 31'd4, 1'b0);
		add_cols(7'd64);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_COLUMN_WRITE) begin
				drain_block();
				write_column_count(stim_table[i].cols);
			end else begin
				push_element(stim_table[i].elem, stim_table[i].fin,
					stim_table[i].typed, stim_table[i].res);
			end
		end

		// extreme values both ways, no idling so it runs at full rate
		drain_block();
		write_column_count(7'd2);
		gaps_on = 1'b0;
		flood_rows(16'sh7FFF, FLOOD_ROWS, 1'b1);
		flood_rows(16'sh8000, FLOOD_ROWS, 1'b0);
		flood_rows(16'sh7FFF, 1, 1'b1);

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 0) begin
				cc = 7'd2;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						cc = ($urandom_range(0, 1) == 0) ? CC_W'($urandom_range(0, 1))
							: CC_W'($urandom_range(65, 127));
					end
					1: begin
						cc = 7'd64;
					end
					default: begin
						cc = CC_W'($urandom_range(2, 8));
					end
				endcase
			end
			drain_block();
			write_column_count(cc);
			m = cols_in_use();
			if (phase == 0) begin
				// results pile up behind a long receiver stall
				gaps_on = 1'b0;
				long_hold_req = 1'b1;
				n_mats = 30;
			end else begin
				gaps_on = ($urandom_range(0, 3) != 0);
				n_mats = $urandom_range(2, 6);
			end
			for (int k = 0; k < n_mats; k++) begin
				if (phase == 0) rows = 1;
				else if (m <= 8 && $urandom_range(0, 7) == 0) rows = $urandom_range(6, 20);
				else rows = $urandom_range(1, (m <= 8) ? 4 : 2);
				len = rows * m;
				style = (phase == 0) ? 9 : $urandom_range(0, 9);
				if (style <= 1) len = $urandom_range(1, len);
				for (int i = 0; i < len; i++) begin
					// an unterminated matrix runs on into the next one
					push_element(rand_element(), (i == len - 1) && (style != 2), 1'b0, '0);
					random_items++;
				end
			end
			phase++;
		end

		drain_block();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
src/mpsw_pkg.sv
src/mpsw_row_store.sv
src/mpsw_cfg.sv
src/mpsw_core.sv
src/max_path_sum_wrapped_grid_top.sv
test/tb_max_path_sum_wrapped_grid_top.sv
